### rtl/owm_pkg.sv
package owm_pkg;

  localparam int COUNT_BITS = 10;
  localparam int REG_COUNT  = 8;
  localparam int REG_IDX_W  = $clog2(REG_COUNT);

  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [REG_IDX_W-1:0]  reg_idx_t;

  // Action codes carried by an input beat
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_RESET = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_NONE        = 2'd0;
  localparam logic [1:0] ERR_NO_PRESENCE = 2'd1;
  localparam logic [1:0] ERR_STUCK_LOW   = 2'd2;
  localparam logic [1:0] ERR_BUSY        = 2'd3;

  // Register indexes
  localparam reg_idx_t REG_RESET_LOW    = 3'd0;
  localparam reg_idx_t REG_PRESENCE_WAIT = 3'd1;
  localparam reg_idx_t REG_RELEASE_TMO  = 3'd2;
  localparam reg_idx_t REG_SLOT_START   = 3'd3;
  localparam reg_idx_t REG_WRITE_HOLD   = 3'd4;
  localparam reg_idx_t REG_RECOVERY     = 3'd5;
  localparam reg_idx_t REG_READ_LOW     = 3'd6;
  localparam reg_idx_t REG_READ_TAIL    = 3'd7;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
    logic       line_level;
  } in_item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_value;
    logic [1:0] error_code;
  } out_item_t;

  // A zero length acts as one tick
  function automatic cnt_t span(input cnt_t v);
    span = (v == '0) ? cnt_t'(1) : v;
  endfunction

endpackage

### rtl/owm_core.sv
module owm_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  owm_pkg::in_item_t item,
  input  logic              cfg_we,
  input  owm_pkg::reg_idx_t cfg_idx,
  input  owm_pkg::cnt_t     cfg_val,
  output owm_pkg::out_item_t result
);
  import owm_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_RST_WAIT,
    PH_RST_REL,
    PH_RST_REC,
    PH_WR_LOW,
    PH_WR_HOLD,
    PH_WR_REC,
    PH_RD_LOW,
    PH_RD_TAIL
  } phase_t;

  cnt_t reset_low, presence_wait, release_tmo, slot_start;
  cnt_t write_hold, recovery, read_low, read_tail;

  phase_t     phase, phase_next;
  cnt_t       tick_count, tick_count_next;
  logic [2:0] bit_index, bit_index_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic       presence_seen, presence_seen_next;
  logic [1:0] last_error, last_error_next;
  logic [7:0] read_hold, read_hold_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      reset_low     <= cnt_t'(500);
      presence_wait <= cnt_t'(50);
      release_tmo   <= cnt_t'(240);
      slot_start    <= cnt_t'(15);
      write_hold    <= cnt_t'(60);
      recovery      <= cnt_t'(10);
      read_low      <= cnt_t'(14);
      read_tail     <= cnt_t'(75);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_RESET_LOW:     reset_low     <= cfg_val;
        REG_PRESENCE_WAIT: presence_wait <= cfg_val;
        REG_RELEASE_TMO:   release_tmo   <= cfg_val;
        REG_SLOT_START:    slot_start    <= cfg_val;
        REG_WRITE_HOLD:    write_hold    <= cfg_val;
        REG_RECOVERY:      recovery      <= cfg_val;
        REG_READ_LOW:      read_low      <= cfg_val;
        REG_READ_TAIL:     read_tail     <= cfg_val;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_t               ph;
    cnt_t                 tc;
    cnt_t                 lim;
    logic [COUNT_BITS:0]  tc_inc;
    logic                 hit;
    logic                 drive, done, rejected;

    ph              = phase;
    tc              = tick_count;
    bit_index_next  = bit_index;
    shift_byte_next = shift_byte;
    presence_seen_next = presence_seen;
    last_error_next = last_error;
    read_hold_next  = read_hold;
    drive    = 1'b0;
    done     = 1'b0;
    rejected = 1'b0;

    if (ph == PH_IDLE) begin
      if (item.action != ACT_NONE) begin
        tc              = '0;
        bit_index_next  = '0;
        last_error_next = ERR_NONE;
        if (item.action == ACT_RESET) begin
          ph = PH_RST_LOW;
        end else if (item.action == ACT_WRITE) begin
          shift_byte_next = item.data_byte;
          ph = PH_WR_LOW;
        end else begin
          shift_byte_next = '0;
          ph = PH_RD_LOW;
        end
      end
    end else if (item.action != ACT_NONE) begin
      rejected = 1'b1;
    end

    // Pick the length that times the current part of the slot
    unique case (ph)
      PH_RST_LOW:  lim = span(reset_low);
      PH_RST_WAIT: lim = span(presence_wait);
      PH_RST_REL:  lim = span(release_tmo);
      PH_RST_REC,
      PH_WR_REC:   lim = span(recovery);
      PH_WR_LOW:   lim = span(slot_start);
      PH_WR_HOLD:  lim = span(write_hold);
      PH_RD_LOW:   lim = span(read_low);
      PH_RD_TAIL:  lim = span(read_tail);
      default:     lim = cnt_t'(1);
    endcase
    tc_inc = {1'b0, tc} + (COUNT_BITS+1)'(1);
    hit    = tc_inc >= {1'b0, lim};

    phase_next      = ph;
    tick_count_next = hit ? '0 : tc_inc[COUNT_BITS-1:0];

    unique case (ph)
      PH_RST_LOW: begin
        drive = 1'b1;
        if (hit) phase_next = PH_RST_WAIT;
      end
      PH_RST_WAIT: begin
        if (hit) begin
          presence_seen_next = ~item.line_level;
          phase_next = item.line_level ? PH_RST_REC : PH_RST_REL;
        end
      end
      PH_RST_REL: begin
        if (item.line_level) begin
          tick_count_next = '0;
          phase_next      = PH_RST_REC;
        end else if (hit) begin
          last_error_next    = ERR_STUCK_LOW;
          presence_seen_next = 1'b0;
          phase_next         = PH_RST_REC;
        end
      end
      PH_RST_REC: begin
        if (hit) begin
          if (last_error_next == ERR_NONE && !presence_seen_next)
            last_error_next = ERR_NO_PRESENCE;
          phase_next = PH_IDLE;
          done       = 1'b1;
        end
      end
      PH_WR_LOW: begin
        drive = 1'b1;
        if (hit) phase_next = PH_WR_HOLD;
      end
      PH_WR_HOLD: begin
        drive = ~shift_byte_next[0];
        if (hit) phase_next = PH_WR_REC;
      end
      PH_WR_REC: begin
        if (hit) begin
          shift_byte_next = {1'b0, shift_byte_next[7:1]};
          if (bit_index_next == 3'd7) begin
            bit_index_next = '0;
            phase_next     = PH_IDLE;
            done           = 1'b1;
          end else begin
            bit_index_next = bit_index_next + 3'd1;
            phase_next     = PH_WR_LOW;
          end
        end
      end
      PH_RD_LOW: begin
        drive = 1'b1;
        if (hit) phase_next = PH_RD_TAIL;
      end
      PH_RD_TAIL: begin
        // sample on the first released tick
        if (tc == '0) shift_byte_next = {item.line_level, shift_byte_next[7:1]};
        if (hit) begin
          if (bit_index_next == 3'd7) begin
            bit_index_next = '0;
            read_hold_next = shift_byte_next;
            phase_next     = PH_IDLE;
            done           = 1'b1;
          end else begin
            bit_index_next = bit_index_next + 3'd1;
            phase_next     = PH_RD_LOW;
          end
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        tick_count_next = '0;
      end
    endcase

    result.drive_low  = drive;
    result.busy_res   = (phase_next != PH_IDLE);
    result.done_res   = done;
    result.presence   = presence_seen_next;
    result.read_value = read_hold_next;
    result.error_code = rejected ? ERR_BUSY : last_error_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_count    <= '0;
      bit_index     <= '0;
      shift_byte    <= '0;
      presence_seen <= 1'b0;
      last_error    <= ERR_NONE;
      read_hold     <= '0;
    end else if (step) begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      bit_index     <= bit_index_next;
      shift_byte    <= shift_byte_next;
      presence_seen <= presence_seen_next;
      last_error    <= last_error_next;
      read_hold     <= read_hold_next;
    end
  end

endmodule

### rtl/onewire_master_byte_engine_top.sv
// 1-Wire bus master: each input beat is one microsecond tick with the sampled
// bus level and an optional command (reset/presence, write byte, read byte),
// and it yields exactly one result beat with the drive level for that tick,
// busy, done, presence, the last byte read and an error code. A new beat is
// taken every cycle while in_ready is high; its result is registered. The result
// register is backed by a one-entry skid stage, so input stays ready while a
// single result waits; in_ready drops only once two results are held. Bus
// timing is counted in ticks by one 10-bit counter against the eight
// configuration registers, which are written through cfg_* (always ready,
// write only while no operation is running).
module onewire_master_byte_engine_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  owm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output owm_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  owm_pkg::reg_idx_t  cfg_index,
  input  owm_pkg::cnt_t      cfg_data
);
  import owm_pkg::*;

  logic      accept;
  out_item_t result;
  logic      skid_valid;
  out_item_t skid_data;

  assign cfg_ready = 1'b1;
  assign in_ready  = ~skid_valid;
  assign accept    = in_valid & in_ready;

  owm_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (accept),
    .item    (in_data),
    .cfg_we  (cfg_valid),
    .cfg_idx (cfg_index),
    .cfg_val (cfg_data),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        // drain the skid entry first
        out_valid  <= 1'b1;
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
        if (accept) out_data <= result;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
      skid_data  <= result;
    end
  end

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without an output beat");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !out_ready && accept))
    else $error("skid filled without a stalled output");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.done_res && out_data.busy_res))
    else $error("done and busy in the same beat");
`endif

endmodule

### dv/onewire_bus_checker.sv
module onewire_bus_checker
  import owm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  reg_idx_t  cfg_index,
  input  cnt_t      cfg_data,
  output int        mismatch_count,
  output int        results_pending,
  output logic      op_running
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [3:0] {
    BUS_IDLE,
    RST_LOW,
    RST_WAIT,
    RST_RELEASE,
    RST_RECOVER,
    WR_LOW,
    WR_HOLD,
    WR_RECOVER,
    RD_LOW,
    RD_TAIL
  } bus_phase_t;

  cnt_t       len_reg [REG_COUNT];
  bus_phase_t ph;
  int         slot_ticks;
  logic [2:0] bit_num;
  logic [7:0] shifter;
  logic       presence_seen;
  logic [1:0] op_error;
  logic [7:0] read_byte;
  out_item_t  expected_ticks [$];
  int         fails = 0;

  // A zero length counts as a single tick
  function automatic bit slot_elapsed(input reg_idx_t r);
    int limit;
    limit = (len_reg[r] == '0) ? 1 : int'(len_reg[r]);
    slot_ticks++;
    if (slot_ticks >= limit) begin
      slot_ticks = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic out_item_t predict_bus_tick(input in_item_t beat);
    out_item_t res;
    logic      drive;
    logic      done;
    logic      rejected;
    drive    = 1'b0;
    done     = 1'b0;
    rejected = 1'b0;

    if (ph == BUS_IDLE) begin
      if (beat.action != ACT_NONE) begin
        slot_ticks = 0;
        bit_num    = '0;
        op_error   = ERR_NONE;
        if (beat.action == ACT_RESET) begin
          ph = RST_LOW;
        end else if (beat.action == ACT_WRITE) begin
          shifter = beat.data_byte;
          ph      = WR_LOW;
        end else begin
          shifter = '0;
          ph      = RD_LOW;
        end
      end
    end else if (beat.action != ACT_NONE) begin
      rejected = 1'b1;
    end

    case (ph)
      RST_LOW: begin
        drive = 1'b1;
        if (slot_elapsed(REG_RESET_LOW)) ph = RST_WAIT;
      end
      RST_WAIT: begin
        if (slot_elapsed(REG_PRESENCE_WAIT)) begin
          presence_seen = !beat.line_level;
          ph = presence_seen ? RST_RELEASE : RST_RECOVER;
        end
      end
      RST_RELEASE: begin
        if (beat.line_level) begin
          slot_ticks = 0;
          ph         = RST_RECOVER;
        end else if (slot_elapsed(REG_RELEASE_TMO)) begin
          op_error      = ERR_STUCK_LOW;
          presence_seen = 1'b0;
          ph            = RST_RECOVER;
        end
      end
      RST_RECOVER: begin
        if (slot_elapsed(REG_RECOVERY)) begin
          if (op_error == ERR_NONE && !presence_seen) op_error = ERR_NO_PRESENCE;
          ph   = BUS_IDLE;
          done = 1'b1;
        end
      end
      WR_LOW: begin
        drive = 1'b1;
        if (slot_elapsed(REG_SLOT_START)) ph = WR_HOLD;
      end
      WR_HOLD: begin
        drive = !shifter[0];
        if (slot_elapsed(REG_WRITE_HOLD)) ph = WR_RECOVER;
      end
      WR_RECOVER: begin
        if (slot_elapsed(REG_RECOVERY)) begin
          shifter = shifter >> 1;
          if (&bit_num) begin
            bit_num = '0;
            ph      = BUS_IDLE;
            done    = 1'b1;
          end else begin
            bit_num = bit_num + 3'd1;
            ph      = WR_LOW;
          end
        end
      end
      RD_LOW: begin
        drive = 1'b1;
        if (slot_elapsed(REG_READ_LOW)) ph = RD_TAIL;
      end
      RD_TAIL: begin
        // sample on the first released tick, LSB arrives first
        if (slot_ticks == 0) shifter = {beat.line_level, shifter[7:1]};
        if (slot_elapsed(REG_READ_TAIL)) begin
          if (&bit_num) begin
            bit_num   = '0;
            read_byte = shifter;
            ph        = BUS_IDLE;
            done      = 1'b1;
          end else begin
            bit_num = bit_num + 3'd1;
            ph      = RD_LOW;
          end
        end
      end
      default: ;
    endcase

    res.drive_low  = drive;
    res.busy_res   = (ph != BUS_IDLE);
    res.done_res   = done;
    res.presence   = presence_seen;
    res.read_value = read_byte;
    res.error_code = rejected ? ERR_BUSY : op_error;
    return res;
  endfunction

  task automatic compare_field(input string field, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      len_reg[REG_RESET_LOW]     = 10'd500;
      len_reg[REG_PRESENCE_WAIT] = 10'd50;
      len_reg[REG_RELEASE_TMO]   = 10'd240;
      len_reg[REG_SLOT_START]    = 10'd15;
      len_reg[REG_WRITE_HOLD]    = 10'd60;
      len_reg[REG_RECOVERY]      = 10'd10;
      len_reg[REG_READ_LOW]      = 10'd14;
      len_reg[REG_READ_TAIL]     = 10'd75;
      ph            = BUS_IDLE;
      slot_ticks    = 0;
      bit_num       = '0;
      shifter       = '0;
      presence_seen = 1'b0;
      op_error      = ERR_NONE;
      read_byte     = '0;
      expected_ticks.delete();
    end else begin
      // retire the older result before predicting the new beat
      if (out_valid && out_ready) begin
        if (expected_ticks.size() == 0) begin
          $error("result beat with no expectation waiting");
          fails++;
        end else begin
          want = expected_ticks.pop_front();
          compare_field("drive_low", want.drive_low, out_data.drive_low);
          compare_field("busy_res", want.busy_res, out_data.busy_res);
          compare_field("done_res", want.done_res, out_data.done_res);
          compare_field("presence", want.presence, out_data.presence);
          compare_field("read_value", want.read_value, out_data.read_value);
          compare_field("error_code", want.error_code, out_data.error_code);
        end
      end
      if (cfg_valid && cfg_ready) len_reg[cfg_index] = cfg_data;
      if (in_valid && in_ready) expected_ticks.push_back(predict_bus_tick(in_data));
    end
    mismatch_count  <= fails;
    results_pending <= expected_ticks.size();
    op_running      <= (ph != BUS_IDLE);
  end

endmodule

### dv/tb_onewire_master_byte_engine_top.sv
module tb_onewire_master_byte_engine_top;
  timeunit 1ns;
  timeprecision 1ps;
  import owm_pkg::*;

  typedef enum {
    NO_DEVICE,
    DEVICE_ANSWERS,
    DEVICE_STUCK,
    LINE_RANDOM,
    LINE_ALL_HIGH,
    LINE_ALL_LOW
  } bus_scene_t;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_ready = 1'b0;
  logic      cfg_valid = 1'b0;
  reg_idx_t  cfg_index = '0;
  cnt_t      cfg_data  = '0;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_data;
  logic      cfg_ready;
  int        mismatch_count;
  int        results_pending;
  logic      op_running;

  // lengths as last written, used to time each operation
  cnt_t bus_len [REG_COUNT] = '{10'd500, 10'd50, 10'd240, 10'd15,
                                10'd60, 10'd10, 10'd14, 10'd75};
  int   ticks_sent = 0;
  int   send_quiet = 0;

  onewire_master_byte_engine_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  onewire_bus_checker bus_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending),
    .op_running      (op_running)
  );

  always #10 clk = ~clk;

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return 0;
    if (roll < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic cnt_t rand_len();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 9) return cnt_t'($urandom_range(5, 12));
    return cnt_t'($urandom_range(1, 4));
  endfunction

  function automatic int span_of(input reg_idx_t r);
    return (bus_len[r] == '0) ? 1 : int'(bus_len[r]);
  endfunction

  task automatic send_tick(input logic [1:0] act, input logic [7:0] dbyte, input logic lv);
    in_item_t beat;
    int       gap;
    beat.action     = act;
    beat.data_byte  = dbyte;
    beat.line_level = lv;
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ticks_sent++;
    if (send_quiet > 0) send_quiet--;
    else if ($urandom_range(0, 19) == 0) send_quiet = $urandom_range(50, 300);
    gap = (send_quiet > 0) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain results and tick the bus until the engine is back in idle
  task automatic settle_bus();
    bit running;
    running = 1'b1;
    in_valid <= 1'b0;
    while (running) begin
      repeat (2) @(posedge clk);
      while (results_pending != 0) @(posedge clk);
      repeat (2) @(posedge clk);
      running = op_running;
      if (running) begin
        send_tick(ACT_NONE, 8'h00, 1'b1);
        in_valid <= 1'b0;
      end
    end
  endtask

  task automatic write_reg(input reg_idx_t idx, input cnt_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    bus_len[idx] = val;
  endtask

  task automatic load_regs(input cnt_t val, input bit shuffle);
    settle_bus();
    for (int i = 0; i < REG_COUNT; i++) write_reg(reg_idx_t'(i), shuffle ? rand_len() : val);
    cfg_valid <= 1'b0;
  endtask

  // The command rides on the first of exactly as many ticks as the operation lasts
  task automatic run_op(input logic [1:0] act, input logic [7:0] dbyte,
                        input bus_scene_t scene, input bit stray);
    int         len;
    int         low_from;
    int         low_until;
    int         slack;
    int         stray_at;
    logic       lv;
    logic [1:0] cmd;
    low_from  = 0;
    low_until = 0;
    case (act)
      ACT_RESET: begin
        low_from  = span_of(REG_RESET_LOW);
        low_until = low_from;
        len = low_from + span_of(REG_PRESENCE_WAIT) + span_of(REG_RECOVERY);
        if (scene == DEVICE_ANSWERS) begin
          // release before the timeout, sometimes on its last tick
          slack = ($urandom_range(0, 3) == 0) ? span_of(REG_RELEASE_TMO) - 1
                                              : $urandom_range(0, 6);
          if (slack >= span_of(REG_RELEASE_TMO)) slack = span_of(REG_RELEASE_TMO) - 1;
          low_until = low_from + span_of(REG_PRESENCE_WAIT) + slack;
          len += slack + 1;
        end else if (scene == DEVICE_STUCK) begin
          low_until = low_from + span_of(REG_PRESENCE_WAIT) + span_of(REG_RELEASE_TMO)
                      + $urandom_range(0, 2);
          len += span_of(REG_RELEASE_TMO);
        end
      end
      ACT_WRITE: begin
        len = 8 * (span_of(REG_SLOT_START) + span_of(REG_WRITE_HOLD) + span_of(REG_RECOVERY));
      end
      default: begin
        len = 8 * (span_of(REG_READ_LOW) + span_of(REG_READ_TAIL));
      end
    endcase
    stray_at = (stray && len > 1) ? $urandom_range(1, len - 1) : -1;
    for (int k = 0; k < len; k++) begin
      if (act == ACT_RESET) lv = (k < low_from) ? 1'($urandom_range(0, 1)) : (k >= low_until);
      else if (scene == LINE_ALL_HIGH) lv = 1'b1;
      else if (scene == LINE_ALL_LOW) lv = 1'b0;
      else lv = 1'($urandom_range(0, 1));
      if (k == 0) cmd = act;
      else if (k == stray_at) cmd = 2'($urandom_range(1, 3));
      else cmd = ACT_NONE;
      send_tick(cmd, (k == 0) ? dbyte : 8'($urandom), lv);
    end
    repeat ($urandom_range(0, 3)) send_tick(ACT_NONE, 8'($urandom), 1'($urandom_range(0, 1)));
  endtask

  initial begin : stimulus
    int         op_num;
    int         roll;
    int         guard;
    bus_scene_t scene;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset-value timing, with the release timeout running out
    run_op(ACT_RESET, 8'h00, DEVICE_STUCK, 1'b1);

    load_regs(10'd1, 1'b0);
    run_op(ACT_RESET, 8'h00, NO_DEVICE, 1'b0);
    run_op(ACT_RESET, 8'h00, DEVICE_STUCK, 1'b0);
    run_op(ACT_RESET, 8'h00, DEVICE_ANSWERS, 1'b1);
    run_op(ACT_WRITE, 8'h00, LINE_RANDOM, 1'b1);
    run_op(ACT_WRITE, 8'hFF, LINE_RANDOM, 1'b0);
    run_op(ACT_READ, 8'h00, LINE_ALL_HIGH, 1'b0);
    run_op(ACT_READ, 8'h00, LINE_ALL_LOW, 1'b1);

    // zero lengths behave as one tick
    load_regs('0, 1'b0);
    run_op(ACT_RESET, 8'h00, DEVICE_ANSWERS, 1'b0);
    run_op(ACT_WRITE, 8'hA5, LINE_RANDOM, 1'b1);
    run_op(ACT_READ, 8'h00, LINE_RANDOM, 1'b0);

    op_num = 0;
    while (ticks_sent < 1750) begin
      if (op_num % 6 == 0) load_regs('0, 1'b1);
      op_num++;
      roll = $urandom_range(0, 9);
      if (roll < 4) begin
        scene = (roll < 2) ? DEVICE_ANSWERS : (roll == 2) ? NO_DEVICE : DEVICE_STUCK;
        run_op(ACT_RESET, 8'($urandom), scene, $urandom_range(0, 3) == 0);
      end else if (roll < 7) begin
        run_op(ACT_WRITE, 8'($urandom), LINE_RANDOM, $urandom_range(0, 3) == 0);
      end else begin
        run_op(ACT_READ, 8'($urandom), LINE_RANDOM, $urandom_range(0, 3) == 0);
      end
    end

    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    guard = 0;
    while (results_pending != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
    if (results_pending != 0) $error("%0d expected results never arrived", results_pending);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : result_sink
    int stall;
    int quiet;
    int beats;
    bit pressed;
    quiet   = 0;
    beats   = 0;
    pressed = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      // hold off long enough for the skid stage to fill and stall the input
      if (!pressed && beats >= 300) begin
        out_ready <= 1'b0;
        repeat (150) @(posedge clk);
        pressed = 1'b1;
      end
      if (quiet > 0) quiet--;
      else if ($urandom_range(0, 19) == 0) quiet = $urandom_range(50, 300);
      stall = (quiet > 0) ? 0 : pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      if (out_valid && out_ready) beats++;
    end
  end

  initial begin : watchdog
    #400_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
